FILE: rtl/core/pqtd_pkg.sv
// shared types, constants and helpers for the query tracker and deframer
// no dependencies; used by every module under rtl/core and by the checker
package pqtd_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned SlotW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned IdW        = 16;
  localparam int unsigned RetryW     = 4;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [RetryW-1:0] RetryMax      = '1;
  localparam logic [RetryW-1:0] RetryLimitRst = RetryW'(3);
  localparam logic              RegRetryLimit = 1'b0;
  localparam logic [IdW-1:0]    MinFrameLen   = IdW'(2);

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_DUPLICATE = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_ANSWERED  = 3'd3,
    KIND_UNMATCHED = 3'd4,
    KIND_MALFORMED = 3'd5,
    KIND_ABORTED   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_SHORT = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_e;

  typedef logic [TableDepth-1:0] slot_mask_t;

  typedef struct packed {
    cmd_e           cmd;
    logic [IdW-1:0] id;
  } cmd_t;

  typedef struct packed {
    kind_e          kind;
    logic           resend;
    logic [IdW-1:0] id;
    logic           last;
  } result_t;

  function automatic logic [SlotW-1:0] lowest_slot(slot_mask_t m);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SlotW'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/pipelined_query_tracker_deframer.sv
// top level: config port, front end, command queue and table back end
// a transaction is written into the command queue, popped by the back end and its result registered before it strobes
// throughput: one send or byte per cycle while busy is low; a close holds the back end until all its results are out
// busy is high while the four-entry command queue is full; results cannot be stalled
// reset: asynchronous active low, clears the deframer and queue and invalidates every table entry
// depends on pqtd_pkg, pqtd_front, pqtd_fifo and pqtd_back
module pipelined_query_tracker_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    op_i,
  input  logic [pqtd_pkg::IdW-1:0]      query_id_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          done_o,
  output logic [2:0]                    kind_o,
  output logic                          resend_o,
  output logic [pqtd_pkg::IdW-1:0]      result_id_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pqtd_pkg::AddrW-1:0]    paddr,
  input  logic [pqtd_pkg::DataW-1:0]    pwdata,
  output logic [pqtd_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [pqtd_pkg::RetryW-1:0]  retry_limit_q;
  logic                         reg_sel;
  logic                         push, pop, full, empty;
  pqtd_pkg::cmd_t               push_cmd, head_cmd;
  pqtd_pkg::result_t            res;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == pqtd_pkg::RegRetryLimit);
  assign prdata  = reg_sel ? pqtd_pkg::DataW'(retry_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= pqtd_pkg::RetryLimitRst;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      retry_limit_q <= pwdata[pqtd_pkg::RetryW-1:0];
    end
  end

  assign busy_o = full;

  pqtd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .op_i       (op_i),
    .query_id_i (query_id_i),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  pqtd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  pqtd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!empty),
    .cmd_i         (head_cmd),
    .retry_limit_i (retry_limit_q),
    .pop_o         (pop),
    .done_o        (done_o),
    .res_o         (res)
  );

  assign kind_o      = res.kind;
  assign resend_o    = res.resend;
  assign result_id_o = res.id;
  assign last_o      = res.last;

endmodule

FILE: rtl/core/pqtd_fifo.sv
// command queue between the classifying front end and the table back end
// depends on pqtd_pkg
module pqtd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pqtd_pkg::cmd_t  data_i,
  input  logic            pop_i,
  output pqtd_pkg::cmd_t  data_o,
  output logic            full_o,
  output logic            empty_o
);

  pqtd_pkg::cmd_t                   mem_q [pqtd_pkg::FifoDepth];
  logic [pqtd_pkg::FifoPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [pqtd_pkg::FifoPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [pqtd_pkg::FifoPtrW:0]      count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == (pqtd_pkg::FifoPtrW + 1)'(pqtd_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/pqtd_front.sv
// front end: takes transactions, runs the length-prefix deframer and
// turns sends, closes and each finished frame into a table command; depends on pqtd_pkg
module pqtd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  op_i,
  input  logic [pqtd_pkg::IdW-1:0]    query_id_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        full_i,
  output logic                        push_o,
  output pqtd_pkg::cmd_t              cmd_o
);

  pqtd_pkg::phase_e             phase_q, phase_d;
  logic [pqtd_pkg::IdW-1:0]     length_q, length_d;
  logic [pqtd_pkg::IdW-1:0]     count_q, count_d;
  logic [pqtd_pkg::IdW-1:0]     reply_q, reply_d;
  logic [pqtd_pkg::IdW-1:0]     len_full;
  logic [pqtd_pkg::IdW-1:0]     count_inc;
  logic                         accept;

  assign accept    = start_i && !full_i;
  assign len_full  = {length_q[15:8], rx_byte_i};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    length_d  = length_q;
    count_d   = count_q;
    reply_d   = reply_q;
    push_o    = 1'b0;
    cmd_o.cmd = pqtd_pkg::CMD_SEND;
    cmd_o.id  = query_id_i;
    if (accept) begin
      case (op_i)
        pqtd_pkg::OP_SEND: begin
          push_o = 1'b1;
        end
        pqtd_pkg::OP_CLOSE: begin
          push_o    = 1'b1;
          cmd_o.cmd = pqtd_pkg::CMD_CLOSE;
          phase_d   = pqtd_pkg::PH_LEN_HI;
          length_d  = '0;
          count_d   = '0;
          reply_d   = '0;
        end
        pqtd_pkg::OP_BYTE: begin
          unique case (phase_q)
            pqtd_pkg::PH_LEN_HI: begin
              length_d = {rx_byte_i, 8'h00};
              phase_d  = pqtd_pkg::PH_LEN_LO;
            end
            pqtd_pkg::PH_LEN_LO: begin
              length_d = len_full;
              count_d  = '0;
              reply_d  = '0;
              if (len_full == '0) begin
                push_o    = 1'b1;
                cmd_o.cmd = pqtd_pkg::CMD_SHORT;
                cmd_o.id  = '0;
                phase_d   = pqtd_pkg::PH_LEN_HI;
              end else begin
                phase_d = pqtd_pkg::PH_BODY;
              end
            end
            pqtd_pkg::PH_BODY: begin
              if (count_q == 16'd0) begin
                reply_d = {rx_byte_i, 8'h00};
              end else if (count_q == 16'd1) begin
                reply_d = {reply_q[15:8], rx_byte_i};
              end
              count_d = count_inc;
              if (count_inc == length_q) begin
                push_o  = 1'b1;
                phase_d = pqtd_pkg::PH_LEN_HI;
                if (length_q < pqtd_pkg::MinFrameLen) begin
                  cmd_o.cmd = pqtd_pkg::CMD_SHORT;
                  cmd_o.id  = '0;
                end else begin
                  cmd_o.cmd = pqtd_pkg::CMD_FRAME;
                  cmd_o.id  = reply_d;
                end
              end
            end
            default: begin
              phase_d = pqtd_pkg::PH_LEN_HI;
            end
          endcase
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pqtd_pkg::PH_LEN_HI;
      length_q <= '0;
      count_q  <= '0;
      reply_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      length_q <= length_d;
      count_q  <= count_d;
      reply_q  <= reply_d;
    end
  end

endmodule

FILE: rtl/core/pqtd_back.sv
// back end: query table, executes commands and drives the result register
// close walks aborted then resend entries one per cycle; depends on pqtd_pkg
module pqtd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  pqtd_pkg::cmd_t                  cmd_i,
  input  logic [pqtd_pkg::RetryW-1:0]     retry_limit_i,
  output logic                            pop_o,
  output logic                            done_o,
  output pqtd_pkg::result_t               res_o
);

  localparam int unsigned Depth = pqtd_pkg::TableDepth;

  pqtd_pkg::back_state_e              state_q, state_d;
  pqtd_pkg::slot_mask_t               valid_q;
  logic [pqtd_pkg::IdW-1:0]           id_q [Depth];
  logic [pqtd_pkg::RetryW-1:0]        retries_q [Depth];
  logic [pqtd_pkg::RetryW-1:0]        retries_inc [Depth];
  pqtd_pkg::slot_mask_t               abort_q, abort_d;
  pqtd_pkg::slot_mask_t               keep_q, keep_d;
  pqtd_pkg::slot_mask_t               match_vec, abort_vec;
  logic                               done_d;
  pqtd_pkg::result_t                  res_d;
  logic                               set_en, zero_en, clr_en, close_en;
  logic [pqtd_pkg::SlotW-1:0]         set_slot, zero_slot, clr_slot, scan_slot;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match_vec[i]   = valid_q[i] && (id_q[i] == cmd_i.id);
      retries_inc[i] = (retries_q[i] == pqtd_pkg::RetryMax) ? retries_q[i]
                                                            : retries_q[i] + 1'b1;
      abort_vec[i]   = valid_q[i] && (retries_inc[i] > retry_limit_i);
    end
  end

  always_comb begin
    state_d    = state_q;
    abort_d    = abort_q;
    keep_d     = keep_q;
    pop_o      = 1'b0;
    done_d     = 1'b0;
    res_d      = res_o;
    set_en     = 1'b0;
    zero_en    = 1'b0;
    clr_en     = 1'b0;
    close_en   = 1'b0;
    set_slot   = pqtd_pkg::lowest_slot(~valid_q);
    zero_slot  = pqtd_pkg::lowest_slot(match_vec);
    clr_slot   = zero_slot;
    scan_slot  = (abort_q != '0) ? pqtd_pkg::lowest_slot(abort_q)
                                 : pqtd_pkg::lowest_slot(keep_q);
    unique case (state_q)
      pqtd_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o        = 1'b1;
          res_d.resend = 1'b0;
          res_d.id     = cmd_i.id;
          res_d.last   = 1'b1;
          unique case (cmd_i.cmd)
            pqtd_pkg::CMD_SEND: begin
              done_d = 1'b1;
              if (match_vec != '0) begin
                zero_en    = 1'b1;
                res_d.kind = pqtd_pkg::KIND_DUPLICATE;
              end else if (valid_q != '1) begin
                set_en     = 1'b1;
                res_d.kind = pqtd_pkg::KIND_ACCEPTED;
              end else begin
                res_d.kind = pqtd_pkg::KIND_FULL;
              end
            end
            pqtd_pkg::CMD_FRAME: begin
              done_d = 1'b1;
              if (match_vec != '0) begin
                clr_en     = 1'b1;
                res_d.kind = pqtd_pkg::KIND_ANSWERED;
              end else begin
                res_d.kind = pqtd_pkg::KIND_UNMATCHED;
              end
            end
            pqtd_pkg::CMD_SHORT: begin
              done_d     = 1'b1;
              res_d.kind = pqtd_pkg::KIND_MALFORMED;
              res_d.id   = '0;
            end
            pqtd_pkg::CMD_CLOSE: begin
              close_en = 1'b1;
              abort_d  = abort_vec;
              keep_d   = valid_q & ~abort_vec;
              if (valid_q != '0) begin
                state_d = pqtd_pkg::BK_SCAN;
              end
            end
            default: begin
              done_d = 1'b0;
            end
          endcase
        end
      end
      pqtd_pkg::BK_SCAN: begin
        done_d   = 1'b1;
        res_d.id = id_q[scan_slot];
        if (abort_q != '0) begin
          abort_d      = abort_q & (abort_q - 1'b1);
          res_d.kind   = pqtd_pkg::KIND_ABORTED;
          res_d.resend = 1'b0;
        end else begin
          keep_d       = keep_q & (keep_q - 1'b1);
          res_d.kind   = pqtd_pkg::KIND_ACCEPTED;
          res_d.resend = 1'b1;
        end
        res_d.last = (abort_d == '0) && (keep_d == '0);
        if (res_d.last) begin
          state_d = pqtd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = pqtd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqtd_pkg::BK_IDLE;
      valid_q <= '0;
      abort_q <= '0;
      keep_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      abort_q <= abort_d;
      keep_q  <= keep_d;
      done_o  <= done_d;
      if (close_en) begin
        valid_q <= valid_q & ~abort_vec;
      end else if (set_en) begin
        valid_q[set_slot] <= 1'b1;
      end else if (clr_en) begin
        valid_q[clr_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
    if (close_en) begin
      for (int i = 0; i < Depth; i++) begin
        if (valid_q[i]) begin
          retries_q[i] <= retries_inc[i];
        end
      end
    end else if (set_en) begin
      id_q[set_slot]      <= cmd_i.id;
      retries_q[set_slot] <= '0;
    end else if (zero_en) begin
      retries_q[zero_slot] <= '0;
    end
  end

endmodule

FILE: rtl/core/pqtd_checker.sv
// port-level checks for the query tracker, bound to the top level
// depends on pqtd_pkg and pipelined_query_tracker_deframer
module pqtd_port_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        done_o,
  input logic [2:0]                  kind_o,
  input logic                        resend_o,
  input logic [pqtd_pkg::IdW-1:0]    result_id_o,
  input logic                        last_o,
  input logic                        pready
);

  a_resend_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && resend_o |-> kind_o == pqtd_pkg::KIND_ACCEPTED)
    else $error("resend result with wrong kind");

  a_malformed_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && kind_o == pqtd_pkg::KIND_MALFORMED |-> result_id_o == '0)
    else $error("malformed result carries an id");

  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o)
    else $error("gap inside a close burst");

  a_resend_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && resend_o && !last_o |=> resend_o)
    else $error("aborted result after a resend result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind pipelined_query_tracker_deframer pqtd_port_checker u_pqtd_checker (.*);

FILE: tb/pqtd_checker.sv
// checker for the query tracker and deframer: predicts every result from the
// accepted transactions and config writes, then compares the result strobes
// depends on pqtd_pkg
module pqtd_checker
  import pqtd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         op_i,
  input  logic [IdW-1:0]     query_id_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               done_i,
  input  logic [2:0]         kind_i,
  input  logic               resend_i,
  input  logic [IdW-1:0]     result_id_i,
  input  logic               last_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [AddrW-1:0]   paddr_i,
  input  logic [DataW-1:0]   pwdata_i,
  input  logic               pready_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AddrW-1:0] RetryLimitAddr = AddrW'(4 * RegRetryLimit);

  phase_e            deframe_phase;
  logic [IdW-1:0]    frame_len;
  logic [IdW-1:0]    body_seen;
  logic [IdW-1:0]    reply_id;
  slot_mask_t        slot_used;
  logic [IdW-1:0]    slot_id [TableDepth];
  logic [RetryW-1:0] slot_tries [TableDepth];
  logic [RetryW-1:0] retry_limit;
  result_t           awaited_reports [$];
  int unsigned       mismatch_total;

  function automatic result_t make_report(kind_e k, logic rs, logic [IdW-1:0] id);
    result_t r;
    r.kind   = k;
    r.resend = rs;
    r.id     = id;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic int find_slot(logic [IdW-1:0] id);
    int hit;
    hit = -1;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_id[i] == id) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  function automatic result_t close_frame();
    int slot;
    deframe_phase = PH_LEN_HI;
    if (frame_len < MinFrameLen) begin
      return make_report(KIND_MALFORMED, 1'b0, '0);
    end
    slot = find_slot(reply_id);
    if (slot >= 0) begin
      slot_used[slot] = 1'b0;
      return make_report(KIND_ANSWERED, 1'b0, reply_id);
    end
    return make_report(KIND_UNMATCHED, 1'b0, reply_id);
  endfunction

  task automatic advance_tracker(logic [1:0] op, logic [IdW-1:0] qid, logic [7:0] b);
    result_t batch [$];
    int      slot;
    case (op)
      OP_SEND: begin
        slot = find_slot(qid);
        if (slot >= 0) begin
          slot_tries[slot] = '0;
          batch.push_back(make_report(KIND_DUPLICATE, 1'b0, qid));
        end else begin
          for (int i = TableDepth - 1; i >= 0; i--) begin
            if (!slot_used[i]) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            slot_used[slot]  = 1'b1;
            slot_id[slot]    = qid;
            slot_tries[slot] = '0;
            batch.push_back(make_report(KIND_ACCEPTED, 1'b0, qid));
          end else begin
            batch.push_back(make_report(KIND_FULL, 1'b0, qid));
          end
        end
      end
      OP_BYTE: begin
        case (deframe_phase)
          PH_LEN_HI: begin
            frame_len     = {b, 8'h00};
            deframe_phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            frame_len[7:0] = b;
            body_seen      = '0;
            reply_id       = '0;
            deframe_phase  = PH_BODY;
            if (frame_len == '0) begin
              batch.push_back(close_frame());
            end
          end
          default: begin
            if (body_seen == 0) begin
              reply_id = {b, 8'h00};
            end else if (body_seen == 1) begin
              reply_id[7:0] = b;
            end
            body_seen = body_seen + 1'b1;
            if (body_seen == frame_len) begin
              batch.push_back(close_frame());
            end
          end
        endcase
      end
      OP_CLOSE: begin
        deframe_phase = PH_LEN_HI;
        frame_len     = '0;
        body_seen     = '0;
        reply_id      = '0;
        for (int i = 0; i < TableDepth; i++) begin
          if (slot_used[i]) begin
            if (slot_tries[i] != RetryMax) begin
              slot_tries[i] = slot_tries[i] + 1'b1;
            end
            if (slot_tries[i] > retry_limit) begin
              slot_used[i] = 1'b0;
              batch.push_back(make_report(KIND_ABORTED, 1'b0, slot_id[i]));
            end
          end
        end
        for (int i = 0; i < TableDepth; i++) begin
          if (slot_used[i]) begin
            batch.push_back(make_report(KIND_ACCEPTED, 1'b1, slot_id[i]));
          end
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[k]) begin
      awaited_reports.push_back(batch[k]);
    end
  endtask

  task automatic check_field(string what, logic [IdW-1:0] want, logic [IdW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      deframe_phase = PH_LEN_HI;
      frame_len     = '0;
      body_seen     = '0;
      reply_id      = '0;
      slot_used     = '0;
      retry_limit   = RetryLimitRst;
      awaited_reports.delete();
      mismatch_total = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual kind %0d id %0h",
                   $time, kind_i, result_id_i);
          mismatch_total++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("kind", IdW'(want.kind), IdW'(kind_i));
          check_field("resend", IdW'(want.resend), IdW'(resend_i));
          check_field("result_id", want.id, result_id_i);
          check_field("last", IdW'(want.last), IdW'(last_i));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RetryLimitAddr) begin
        retry_limit = pwdata_i[RetryW-1:0];
      end
      if (start_i && !busy_i) begin
        advance_tracker(op_i, query_id_i, rx_byte_i);
      end
      mismatches_o  <= mismatch_total;
      outstanding_o <= awaited_reports.size();
    end
  end

endmodule

FILE: tb/tb_pipelined_query_tracker_deframer.sv
// testbench top for the query tracker and deframer: clock, reset, directed and
// random transactions, retry limit writes over the config port, final verdict
// depends on pqtd_pkg, pipelined_query_tracker_deframer and pqtd_checker
module tb_pipelined_query_tracker_deframer;

  import pqtd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AddrW-1:0] RetryLimitAddr = AddrW'(4 * RegRetryLimit);
  localparam int               OpUnused       = 3;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         op_i;
  logic [IdW-1:0]     query_id_i;
  logic [7:0]         rx_byte_i;
  logic               done_o;
  logic [2:0]         kind_o;
  logic               resend_o;
  logic [IdW-1:0]     result_id_o;
  logic               last_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;
  int unsigned        mismatches;
  int unsigned        outstanding;

  int unsigned        item_count;
  bit                 idle_on;
  logic [IdW-1:0]     sent_ids [$];

  pipelined_query_tracker_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .query_id_i  (query_id_i),
    .rx_byte_i   (rx_byte_i),
    .done_o      (done_o),
    .kind_o      (kind_o),
    .resend_o    (resend_o),
    .result_id_o (result_id_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  pqtd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .op_i          (op_i),
    .query_id_i    (query_id_i),
    .rx_byte_i     (rx_byte_i),
    .done_i        (done_o),
    .kind_i        (kind_o),
    .resend_i      (resend_o),
    .result_id_i   (result_id_o),
    .last_i        (last_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic drive_item(logic [1:0] op, logic [IdW-1:0] qid, logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(99) < 29) begin
      gap = $urandom_range(3, 1);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    op_i       <= op;
    query_id_i <= qid;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (busy_o);
    item_count++;
  endtask

  task automatic send_query(logic [IdW-1:0] qid);
    drive_item(OP_SEND, qid, 8'($urandom));
    sent_ids.push_back(qid);
    if (sent_ids.size() > 64) begin
      void'(sent_ids.pop_front());
    end
  endtask

  task automatic stream_byte(logic [7:0] b);
    drive_item(OP_BYTE, IdW'($urandom), b);
  endtask

  task automatic close_link();
    drive_item(OP_CLOSE, IdW'($urandom), 8'($urandom));
  endtask

  task automatic stream_frame(logic [IdW-1:0] len, logic [IdW-1:0] rid);
    stream_byte(len[15:8]);
    stream_byte(len[7:0]);
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        stream_byte(rid[15:8]);
      end else if (k == 1) begin
        stream_byte(rid[7:0]);
      end else begin
        stream_byte(8'($urandom));
      end
    end
  endtask

  // lets the queue drain and any result-free close finish before a register write or the final verdict
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    for (int w = 0; w < 5000; w++) begin
      @(posedge clk_i);
      if (outstanding == 0) begin
        break;
      end
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_retry_limit(logic [RetryW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RetryLimitAddr;
    pwdata  <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [IdW-1:0] pick_id();
    if (sent_ids.size() > 0 && $urandom_range(9) < 7) begin
      return sent_ids[$urandom_range(sent_ids.size() - 1)];
    end
    return IdW'($urandom);
  endfunction

  task automatic random_action();
    int             r;
    int             sel;
    logic [IdW-1:0] len;
    r = $urandom_range(99);
    if (r < 38 || r >= 89) begin
      if (sent_ids.size() > 0 && $urandom_range(3) == 0) begin
        send_query(sent_ids[$urandom_range(sent_ids.size() - 1)]);
      end else begin
        send_query(IdW'($urandom));
      end
    end else if (r < 73) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        len = '0;
      end else if (sel == 1) begin
        len = IdW'(1);
      end else begin
        len = IdW'(2 + $urandom_range(3));
      end
      stream_frame(len, pick_id());
    end else if (r < 80) begin
      stream_byte(8'($urandom));
    end else if (r < 86) begin
      close_link();
    end else begin
      drive_item(2'(OpUnused), IdW'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [RetryW-1:0] limits [4];
    int unsigned       phase_start;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    op_i       = '0;
    query_id_i = '0;
    rx_byte_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    item_count = 0;
    idle_on    = 1'b1;
    limits[0]  = RetryW'(0);
    limits[1]  = RetryW'(14);
    limits[2]  = RetryW'($urandom_range(13, 1));
    limits[3]  = RetryLimitRst;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty close, unused op, id extremes, duplicate, short and long frames, a frame cut short by a close
    close_link();
    drive_item(2'(OpUnused), IdW'($urandom), 8'($urandom));
    send_query(16'h0000);
    send_query(16'hFFFF);
    send_query(16'hFFFF);
    stream_frame(IdW'(0), '0);
    stream_frame(IdW'(1), 16'hAB00);
    stream_frame(IdW'(2), 16'hFFFF);
    stream_frame(IdW'(3), 16'h1234);
    close_link();
    stream_byte(8'hFF);
    stream_byte(8'hFF);
    close_link();

    for (int p = 0; p < 4; p++) begin
      settle();
      write_retry_limit(limits[p]);
      idle_on     = (p != 1);
      phase_start = item_count;
      // enough fresh ids to overflow the table
      repeat (TableDepth + 1) send_query(IdW'($urandom));
      while (item_count - phase_start < 50) begin
        random_action();
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: pipelined_query_tracker_deframer.f
rtl/core/pqtd_pkg.sv
rtl/core/pqtd_fifo.sv
rtl/core/pqtd_front.sv
rtl/core/pqtd_back.sv
rtl/core/pipelined_query_tracker_deframer.sv
rtl/core/pqtd_checker.sv
tb/pqtd_checker.sv
tb/tb_pipelined_query_tracker_deframer.sv
